@@ hdl/ntce_pkg.sv @@
package ntce_pkg;

    localparam int TableDepth = 16;
    localparam int SlotW = $clog2(TableDepth);

    localparam logic [31:0] TtlReset = 32'd30000000;
    localparam logic [31:0] AdvertReset = 32'd3000000;

    localparam logic [2:0] OP_ADVERT  = 3'd0;
    localparam logic [2:0] OP_RSSI    = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_GCLOCK  = 3'd3;
    localparam logic [2:0] OP_CONVERT = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic REG_TTL    = 1'b0;
    localparam logic REG_ADVERT = 1'b1;

    // one table row as stored in memory
    typedef struct packed {
        logic [47:0] address;
        logic [63:0] rx_time;
        logic [63:0] uptime;
        logic [63:0] global_clk;
        logic [7:0]  rssi;
        logic [63:0] offset;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_ADV_WR,
        S_EL_RD,
        S_EL_CHK,
        S_GCLK_RD,
        S_GCLK_CHK,
        S_TICK_RD,
        S_TICK_CHK,
        S_OUT
    } state_t;

endpackage

@@ hdl/ntce_ram.sv @@
module ntce_ram #(
    parameter int Depth = 16,
    parameter int Width = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/neighbour_table_clock_election.sv @@
// Neighbour table with clock-source election.
// Input channel (in_valid/in_stall from this block): one transaction per
// operation: advertisement, set rssi, housekeeping tick, read global clock,
// convert remote time. Output channel (out_valid, out_stall from receiver):
// exactly one result transaction per accepted input.
// Config channel (cfg_valid/cfg_ready): index 0 ttl_us, 1 advert_interval_us.
// Each operation walks the 16-row table memory row by row, each row a
// registered read, then a compare. A lookup ends at the matching row or
// after the last row. Advertisement: lookup, one write state, then an
// election scan over all rows; on no_space it ends after the lookup. Set
// rssi and convert: lookup only. Read global clock: one read of the source
// row. Tick: the source row read, then the expiry scan, plus a full
// re-election scan for every removed source. Unused op codes: straight out.
// One operation is in flight at a time; the next input is accepted at the
// earliest in the cycle after the result is taken.
// A finished result sits in the output register; the block holds it while
// the receiver stalls and accepts nothing new until it is taken.
// Reset clears valid bits, source, global offset and last advert time;
// row contents are written on insert, so no clearing pass is needed.
module neighbour_table_clock_election (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          op,
    input  logic [47:0]         mac_address,
    input  logic [62:0]         local_time_us,
    input  logic [62:0]         remote_uptime_us,
    input  logic [62:0]         remote_global_us,
    input  logic signed [7:0]   signal_strength,
    input  logic signed [63:0]  remote_time_us,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic signed [63:0]  global_time_us,
    output logic                source_valid,
    output logic [3:0]          source_slot,
    output logic                has_neighbours,
    output logic                advert_due,
    output logic signed [63:0]  converted_time_us,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int SW = ntce_pkg::SlotW;
    localparam int EW = $bits(ntce_pkg::entry_t);

    ntce_pkg::state_t state_reg, state_next;

    // configuration
    logic [31:0] ttl_reg, adv_int_reg;

    // control state
    logic [ntce_pkg::TableDepth-1:0] valid_reg, valid_next;
    logic          src_on_reg, src_on_next;
    logic [SW-1:0] src_idx_reg, src_idx_next;
    logic [63:0]   goff_reg, goff_next;
    logic [63:0]   last_adv_reg, last_adv_next;

    // scan control
    logic [SW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [SW-1:0] hit_reg, hit_next;
    logic          free_reg, free_next;
    logic [SW-1:0] free_idx_reg, free_idx_next;
    logic signed [63:0] best_reg, best_next;
    logic          el_on_reg, el_on_next;
    logic [SW-1:0] el_idx_reg, el_idx_next;
    logic          resume_reg, resume_next;    // election inside tick
    logic [SW-1:0] resume_idx_reg, resume_idx_next;

    // latched input
    logic [2:0]  op_reg;
    logic [47:0] mac_reg;
    logic [63:0] now_reg, upt_reg, glb_reg, rt_reg;
    logic [7:0]  rssi_reg;

    // result
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [63:0] gclk_reg, gclk_next;
    logic        due_reg, due_next;
    logic [63:0] conv_reg, conv_next;

    // memory
    logic                  mem_we;
    logic [SW-1:0]         mem_waddr, mem_raddr;
    ntce_pkg::entry_t      mem_wdata, rd;
    logic [EW-1:0]         rd_bits;

    ntce_ram #(.Depth(ntce_pkg::TableDepth), .Width(EW)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_bits)
    );
    assign rd = ntce_pkg::entry_t'(rd_bits);

    logic in_take, out_take, last_idx;
    logic signed [63:0] key, age;
    logic [63:0] gclk_src;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ntce_pkg::S_IDLE);
    assign cfg_ready = (state_reg == ntce_pkg::S_IDLE) && !out_valid_reg;
    assign last_idx = (idx_reg == SW'(ntce_pkg::TableDepth - 1));
    assign key = signed'(rd.uptime - rd.rx_time);
    assign age = signed'(now_reg - rd.rx_time);
    assign gclk_src = rd.global_clk + (now_reg - rd.rx_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg     <= ntce_pkg::TtlReset;
            adv_int_reg <= ntce_pkg::AdvertReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ntce_pkg::REG_TTL)
            begin
                ttl_reg <= cfg_data;
            end
            else
            begin
                adv_int_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= op;
            mac_reg  <= mac_address;
            now_reg  <= {1'b0, local_time_us};
            upt_reg  <= {1'b0, remote_uptime_us};
            glb_reg  <= {1'b0, remote_global_us};
            rssi_reg <= signal_strength;
            rt_reg   <= remote_time_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ntce_pkg::S_IDLE;
            valid_reg      <= '0;
            src_on_reg     <= 1'b0;
            src_idx_reg    <= '0;
            goff_reg       <= '0;
            last_adv_reg   <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            hit_reg        <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            best_reg       <= '0;
            el_on_reg      <= 1'b0;
            el_idx_reg     <= '0;
            resume_reg     <= 1'b0;
            resume_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ntce_pkg::ST_OK;
            gclk_reg       <= '0;
            due_reg        <= 1'b0;
            conv_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            src_on_reg     <= src_on_next;
            src_idx_reg    <= src_idx_next;
            goff_reg       <= goff_next;
            last_adv_reg   <= last_adv_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            free_idx_reg   <= free_idx_next;
            best_reg       <= best_next;
            el_on_reg      <= el_on_next;
            el_idx_reg     <= el_idx_next;
            resume_reg     <= resume_next;
            resume_idx_reg <= resume_idx_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            gclk_reg       <= gclk_next;
            due_reg        <= due_next;
            conv_reg       <= conv_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntce_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    case (op)
                        ntce_pkg::OP_ADVERT, ntce_pkg::OP_RSSI,
                        ntce_pkg::OP_CONVERT:
                            state_next = ntce_pkg::S_FIND_RD;
                        ntce_pkg::OP_TICK, ntce_pkg::OP_GCLOCK:
                            state_next = ntce_pkg::S_GCLK_RD;
                        default:
                            state_next = ntce_pkg::S_OUT;
                    endcase
                end
            end
            ntce_pkg::S_FIND_RD:  state_next = ntce_pkg::S_FIND_CHK;
            ntce_pkg::S_FIND_CHK:
            begin
                if (valid_reg[idx_reg] && rd.address == mac_reg)
                begin
                    state_next = (op_reg == ntce_pkg::OP_ADVERT) ?
                        ntce_pkg::S_ADV_WR : ntce_pkg::S_OUT;
                end
                else if (last_idx)
                begin
                    state_next = (op_reg == ntce_pkg::OP_ADVERT &&
                        (free_reg || !valid_reg[idx_reg])) ?
                        ntce_pkg::S_ADV_WR : ntce_pkg::S_OUT;
                end
                else
                begin
                    state_next = ntce_pkg::S_FIND_RD;
                end
            end
            ntce_pkg::S_ADV_WR:   state_next = ntce_pkg::S_EL_RD;
            ntce_pkg::S_EL_RD:    state_next = ntce_pkg::S_EL_CHK;
            ntce_pkg::S_EL_CHK:
            begin
                if (!last_idx)
                begin
                    state_next = ntce_pkg::S_EL_RD;
                end
                else if (resume_reg)
                begin
                    state_next = (resume_idx_reg ==
                        SW'(ntce_pkg::TableDepth - 1)) ?
                        ntce_pkg::S_OUT : ntce_pkg::S_TICK_RD;
                end
                else
                begin
                    state_next = ntce_pkg::S_OUT;
                end
            end
            ntce_pkg::S_GCLK_RD:  state_next = ntce_pkg::S_GCLK_CHK;
            ntce_pkg::S_GCLK_CHK:
                state_next = (op_reg == ntce_pkg::OP_TICK) ?
                    ntce_pkg::S_TICK_RD : ntce_pkg::S_OUT;
            ntce_pkg::S_TICK_RD:  state_next = ntce_pkg::S_TICK_CHK;
            ntce_pkg::S_TICK_CHK:
            begin
                if (valid_reg[idx_reg] && age > signed'({32'd0, ttl_reg}) &&
                    src_on_reg && src_idx_reg == idx_reg)
                begin
                    state_next = ntce_pkg::S_EL_RD;
                end
                else
                begin
                    state_next = last_idx ? ntce_pkg::S_OUT : ntce_pkg::S_TICK_RD;
                end
            end
            ntce_pkg::S_OUT:
                state_next = out_take ? ntce_pkg::S_IDLE : ntce_pkg::S_OUT;
            default: state_next = ntce_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        valid_next      = valid_reg;
        src_on_next     = src_on_reg;
        src_idx_next    = src_idx_reg;
        goff_next       = goff_reg;
        last_adv_next   = last_adv_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        el_on_next      = el_on_reg;
        el_idx_next     = el_idx_reg;
        resume_next     = resume_reg;
        resume_idx_next = resume_idx_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        gclk_next       = gclk_reg;
        due_next        = due_reg;
        conv_next       = conv_reg;
        mem_we          = 1'b0;
        mem_waddr       = hit_reg;
        mem_wdata       = rd;
        mem_raddr       = idx_reg;

        case (state_reg)
            ntce_pkg::S_IDLE:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                end
                if (in_take)
                begin
                    idx_next    = '0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    resume_next = 1'b0;
                    status_next = ntce_pkg::ST_OK;
                    gclk_next   = '0;
                    due_next    = 1'b0;
                    conv_next   = '0;
                end
            end
            ntce_pkg::S_FIND_CHK:
            begin
                if (valid_reg[idx_reg] && rd.address == mac_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = idx_reg;
                    if (op_reg == ntce_pkg::OP_RSSI)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = rd;
                        mem_wdata.rssi = rssi_reg;
                    end
                    else if (op_reg == ntce_pkg::OP_CONVERT)
                    begin
                        conv_next = rt_reg + rd.offset;
                    end
                end
                else
                begin
                    if (!valid_reg[idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (last_idx)
                    begin
                        if (op_reg == ntce_pkg::OP_ADVERT)
                        begin
                            if (!(free_reg || !valid_reg[idx_reg]))
                            begin
                                status_next = ntce_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                hit_next = free_reg ? free_idx_reg : idx_reg;
                            end
                        end
                        else if (op_reg == ntce_pkg::OP_RSSI)
                        begin
                            status_next = ntce_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            status_next = ntce_pkg::ST_NOT_FOUND;
                            conv_next   = rt_reg;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + SW'(1);
                    end
                end
            end
            ntce_pkg::S_ADV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = hit_reg;
                mem_wdata.address    = mac_reg;
                mem_wdata.rx_time    = now_reg;
                mem_wdata.uptime     = upt_reg;
                mem_wdata.global_clk = glb_reg;
                mem_wdata.rssi       = found_reg ? rd.rssi : 8'd0;
                mem_wdata.offset     = found_reg ? rd.offset : 64'd0;
                valid_next[hit_reg]  = 1'b1;
                idx_next   = '0;
                best_next  = '0;
                el_on_next = 1'b0;
                el_idx_next = '0;
            end
            ntce_pkg::S_EL_CHK:
            begin
                if (valid_reg[idx_reg] && key > best_reg)
                begin
                    best_next   = key;
                    el_on_next  = 1'b1;
                    el_idx_next = idx_reg;
                end
                if (last_idx)
                begin
                    if (valid_reg[idx_reg] && key > best_reg)
                    begin
                        src_on_next  = 1'b1;
                        src_idx_next = idx_reg;
                    end
                    else
                    begin
                        src_on_next  = el_on_reg;
                        src_idx_next = el_idx_reg;
                    end
                    if (resume_reg)
                    begin
                        idx_next = resume_idx_reg + SW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            ntce_pkg::S_GCLK_RD:
            begin
                mem_raddr = src_idx_reg;
            end
            ntce_pkg::S_GCLK_CHK:
            begin
                gclk_next = src_on_reg ? gclk_src : now_reg + goff_reg;
                if (op_reg == ntce_pkg::OP_TICK)
                begin
                    // clock minus now: the source term reduces to global - rx
                    goff_next = src_on_reg ? rd.global_clk - rd.rx_time : goff_reg;
                    if (signed'(now_reg - last_adv_reg) >=
                        signed'({32'd0, adv_int_reg}) || last_adv_reg == '0)
                    begin
                        due_next      = 1'b1;
                        last_adv_next = now_reg;
                    end
                end
                idx_next = '0;
            end
            ntce_pkg::S_TICK_CHK:
            begin
                if (valid_reg[idx_reg])
                begin
                    if (age > signed'({32'd0, ttl_reg}))
                    begin
                        valid_next[idx_reg] = 1'b0;
                        if (src_on_reg && src_idx_reg == idx_reg)
                        begin
                            resume_next     = 1'b1;
                            resume_idx_next = idx_reg;
                            best_next       = '0;
                            el_on_next      = 1'b0;
                            el_idx_next     = '0;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = rd;
                        mem_wdata.offset = rd.rx_time - rd.uptime;
                    end
                end
                if (valid_reg[idx_reg] && age > signed'({32'd0, ttl_reg}) &&
                    src_on_reg && src_idx_reg == idx_reg)
                begin
                    idx_next = '0;
                end
                else if (!last_idx)
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            ntce_pkg::S_OUT:
            begin
                out_valid_next = !out_take;
            end
            default:
            begin
            end
        endcase
        if (state_next == ntce_pkg::S_OUT && state_reg != ntce_pkg::S_OUT)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign global_time_us    = signed'(gclk_reg);
    assign source_valid      = src_on_reg;
    assign source_slot       = src_on_reg ? 4'(src_idx_reg) : 4'd0;
    assign has_neighbours    = |valid_reg;
    assign advert_due        = due_reg;
    assign converted_time_us = signed'(conv_reg);

`ifndef SYNTHESIS
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ntce_pkg::S_OUT)
        else $error("result shown outside output state");
    a_src_valid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (src_on_reg && state_reg == ntce_pkg::S_IDLE) |-> valid_reg[src_idx_reg])
        else $error("clock source row not valid");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == ntce_pkg::S_IDLE && !out_valid_reg))
        else $error("config taken while busy");
`endif

endmodule

@@ sim/ntce_checker.sv @@
module ntce_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         op,
    input  logic [47:0]        mac_address,
    input  logic [62:0]        local_time_us,
    input  logic [62:0]        remote_uptime_us,
    input  logic [62:0]        remote_global_us,
    input  logic signed [7:0]  signal_strength,
    input  logic signed [63:0] remote_time_us,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic signed [63:0] global_time_us,
    input  logic               source_valid,
    input  logic [3:0]         source_slot,
    input  logic               has_neighbours,
    input  logic               advert_due,
    input  logic signed [63:0] converted_time_us,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] gclk;
        logic        src_valid;
        logic [3:0]  src_slot;
        logic        any;
        logic        due;
        logic [63:0] conv;
    } answer_t;

    answer_t answers_q[$];

    logic [31:0] ttl, adv_int;
    logic        nb_valid [ntce_pkg::TableDepth];
    logic [47:0] nb_addr  [ntce_pkg::TableDepth];
    logic [63:0] nb_rx    [ntce_pkg::TableDepth];
    logic [63:0] nb_up    [ntce_pkg::TableDepth];
    logic [63:0] nb_glob  [ntce_pkg::TableDepth];
    logic [7:0]  nb_rssi  [ntce_pkg::TableDepth];
    logic [63:0] nb_off   [ntce_pkg::TableDepth];
    logic        src_on;
    logic [3:0]  src_idx;
    logic [63:0] gofs, last_adv;

    function automatic int lookup(logic [47:0] a);
        for (int i = 0; i < ntce_pkg::TableDepth; i++)
            if (nb_valid[i] && nb_addr[i] == a)
                return i;
        return -1;
    endfunction

    task automatic elect_source();
        logic signed [63:0] best, key;
        best = 0;
        src_on = 0;
        src_idx = 0;
        for (int i = 0; i < ntce_pkg::TableDepth; i++)
        begin
            if (!nb_valid[i])
                continue;
            key = nb_up[i] - nb_rx[i];
            if (key > best)
            begin
                best = key;
                src_on = 1;
                src_idx = 4'(i);
            end
        end
    endtask

    function automatic logic [63:0] clock_at(logic [63:0] now);
        if (src_on)
            return nb_glob[src_idx] + (now - nb_rx[src_idx]);
        return now + gofs;
    endfunction

    task automatic predict_step();
        answer_t a;
        int s;
        logic [63:0] now;
        logic signed [63:0] age;
        a = '0;
        now = {1'b0, local_time_us};
        case (op)
            ntce_pkg::OP_ADVERT:
            begin
                s = lookup(mac_address);
                if (s < 0)
                begin
                    for (int i = 0; i < ntce_pkg::TableDepth; i++)
                        if (!nb_valid[i])
                        begin
                            s = i;
                            break;
                        end
                    if (s >= 0)
                    begin
                        nb_valid[s] = 1;
                        nb_addr[s] = mac_address;
                        nb_rssi[s] = 0;
                        nb_off[s] = 0;
                    end
                end
                if (s < 0)
                    a.status = ntce_pkg::ST_NO_SPACE;
                else
                begin
                    nb_rx[s] = now;
                    nb_up[s] = {1'b0, remote_uptime_us};
                    nb_glob[s] = {1'b0, remote_global_us};
                    elect_source();
                end
            end
            ntce_pkg::OP_RSSI:
            begin
                s = lookup(mac_address);
                if (s < 0)
                    a.status = ntce_pkg::ST_NOT_FOUND;
                else
                    nb_rssi[s] = signal_strength;
            end
            ntce_pkg::OP_TICK:
            begin
                a.gclk = clock_at(now);
                gofs = a.gclk - now;
                for (int i = 0; i < ntce_pkg::TableDepth; i++)
                begin
                    if (!nb_valid[i])
                        continue;
                    age = now - nb_rx[i];
                    if (age > $signed({32'd0, ttl}))
                    begin
                        nb_valid[i] = 0;
                        if (src_on && src_idx == i)
                            elect_source();
                    end
                    else
                        nb_off[i] = nb_rx[i] - nb_up[i];
                end
                if ($signed(now - last_adv) >= $signed({32'd0, adv_int}) || last_adv == 0)
                begin
                    a.due = 1;
                    last_adv = now;
                end
            end
            ntce_pkg::OP_GCLOCK:
                a.gclk = clock_at(now);
            ntce_pkg::OP_CONVERT:
            begin
                s = lookup(mac_address);
                if (s < 0)
                begin
                    a.status = ntce_pkg::ST_NOT_FOUND;
                    a.conv = remote_time_us;
                end
                else
                    a.conv = remote_time_us + nb_off[s];
            end
            default: ;
        endcase
        a.src_valid = src_on;
        a.src_slot = src_on ? src_idx : 4'd0;
        for (int i = 0; i < ntce_pkg::TableDepth; i++)
            if (nb_valid[i])
                a.any = 1;
        answers_q.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got, want;
        if (!rst_n)
        begin
            ttl = ntce_pkg::TtlReset;
            adv_int = ntce_pkg::AdvertReset;
            for (int i = 0; i < ntce_pkg::TableDepth; i++)
                nb_valid[i] = 0;
            src_on = 0;
            src_idx = 0;
            gofs = 0;
            last_adv = 0;
            answers_q.delete();
            fail_count = 0;
            pending_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ntce_pkg::REG_TTL)
                    ttl = cfg_data;
                else
                    adv_int = cfg_data;
            end
            // compare before predicting: a result always comes later than its input
            if (out_valid && !out_stall)
            begin
                got = '{status, global_time_us, source_valid, source_slot,
                        has_neighbours, advert_due, converted_time_us};
                result_count++;
                if (answers_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %p", got);
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_step();
            pending_count = answers_q.size();
        end
    end
endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 10_000_000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [2:0]         op = 0;
    logic [47:0]        mac_address = 0;
    logic [62:0]        local_time_us = 0;
    logic [62:0]        remote_uptime_us = 0;
    logic [62:0]        remote_global_us = 0;
    logic signed [7:0]  signal_strength = 0;
    logic signed [63:0] remote_time_us = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         status;
    logic signed [63:0] global_time_us;
    logic               source_valid;
    logic [3:0]         source_slot;
    logic               has_neighbours;
    logic               advert_due;
    logic signed [63:0] converted_time_us;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic               cfg_index = 0;
    logic [31:0]        cfg_data = 0;

    int fail_count, pending_count, result_count;
    int cycles = 0;
    int send_idle_pct = 0;   // sender gap chance, percent
    int stall_pct = 0;       // receiver stall chance, percent
    int sent_count = 0;
    int ttl_step = 1_000_000;

    // small pool of addresses so lookups hit and the table fills up
    logic [47:0] addr_pool[20];
    logic [62:0] clock_now;   // advancing local time used by well-formed runs

    always #10 clk = ~clk;

    neighbour_table_clock_election DUT (.*);

    ntce_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall: random per cycle at the current percentage
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // in_valid stays high after acceptance until the next call or drain;
    // the block stalls its input while busy, so nothing is taken twice
    task automatic send_item(input logic [2:0] o, input logic [47:0] a, input logic [62:0] t,
                             input logic [62:0] up, input logic [62:0] gl,
                             input logic [7:0] rs, input logic [63:0] rt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        op <= o;
        mac_address <= a;
        local_time_us <= t;
        remote_uptime_us <= up;
        remote_global_us <= gl;
        signal_strength <= rs;
        remote_time_us <= rt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // wait until every result is back, plus a tail for the block's latency
    task automatic drain();
        in_valid <= 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly realistic traffic on an advancing clock; some fully random noise
    task automatic random_item();
        logic [2:0] o;
        logic [47:0] a;
        logic [62:0] t, up;
        o = $urandom_range(99) < 45 ? ntce_pkg::OP_ADVERT : 3'($urandom_range(7));
        a = addr_pool[$urandom_range(19)];
        if ($urandom_range(9) == 0)
            a = 48'(rand64());
        clock_now = clock_now + $urandom_range(ttl_step);
        t = clock_now;
        up = t + 63'($urandom_range(2_000_000)) - 63'd1_000_000;
        if ($urandom_range(19) == 0)
        begin
            t = 63'(rand64());
            up = 63'(rand64());
        end
        send_item(o, a, t, up, 63'(rand64()), 8'($urandom), rand64());
    endtask

    initial
    begin
        for (int i = 0; i < 20; i++)
            addr_pool[i] = 48'(rand64());
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        clock_now = 63'd1000;
        repeat (7) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: empty-table lookups, extremes, full table, expiry
        send_item(ntce_pkg::OP_GCLOCK, 0, 0, 0, 0, 0, 0);
        send_item(ntce_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        send_item(ntce_pkg::OP_RSSI, '1, 5, 0, 0, 8'h80, 0);
        send_item(ntce_pkg::OP_CONVERT, '1, 5, 0, 0, 0, 64'h8000_0000_0000_0000);
        send_item(ntce_pkg::OP_ADVERT, '0, 100, '1, '1, 8'h7f, '1);
        send_item(ntce_pkg::OP_ADVERT, '1, '1, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_item(ntce_pkg::OP_ADVERT, 48'(i + 2), 63'(200 + i), 63'(500 + i * 7),
                      63'(i), 0, 0);
        send_item(ntce_pkg::OP_RSSI, 48'd3, 0, 0, 0, 8'h7f, 0);
        send_item(ntce_pkg::OP_TICK, 0, 300, 0, 0, 0, 0);
        send_item(ntce_pkg::OP_CONVERT, 48'd3, 0, 0, 0, 0, 64'h7fff_ffff_ffff_ffff);
        send_item(5, 0, 0, 0, 0, 0, 0);
        send_item(7, '1, '1, '1, '1, '1, '1);
        send_item(ntce_pkg::OP_TICK, 0, 63'd40_000_000, 0, 0, 0, 0);
        send_item(ntce_pkg::OP_TICK, 0, '1, 0, 0, 0, 0);
        drain();

        // random phases: idling patterns crossed with register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            case (ph)
                0:
                begin
                    write_reg(ntce_pkg::REG_TTL, 32'd1);
                    write_reg(ntce_pkg::REG_ADVERT, 32'd1);
                end
                2:
                begin
                    write_reg(ntce_pkg::REG_TTL, '1);
                    write_reg(ntce_pkg::REG_ADVERT, '1);
                end
                4:
                begin
                    write_reg(ntce_pkg::REG_TTL, 32'd3_000_000);
                    write_reg(ntce_pkg::REG_ADVERT, 32'd500_000);
                end
                6:
                begin
                    write_reg(ntce_pkg::REG_TTL, $urandom);
                    write_reg(ntce_pkg::REG_ADVERT, $urandom);
                end
                default: ;
            endcase
            ttl_step = (ph % 2) ? 1_000_000 : 200_000;
            repeat (185) random_item();
            drain();
        end

        $display("run covered %0d input transactions and %0d results", sent_count, result_count);
        $display("across four idling patterns and five register settings");
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ neighbour_table_clock_election.f @@
hdl/ntce_pkg.sv
hdl/ntce_ram.sv
hdl/neighbour_table_clock_election.sv
sim/ntce_checker.sv
sim/testbench.sv
